/* rtl/hashed_weighted_select_defines.svh */
// Assertion macros for the RTL (included by hws_ctrl).
// Each expects clk and rst_n in scope.
`ifndef HASHED_WEIGHTED_SELECT_DEFINES_SVH
`define HASHED_WEIGHTED_SELECT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define HWS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HWS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HWS_ASSERT_IMP(label, ante, cons)
`define HWS_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* rtl/hws_pkg.sv */
package hws_pkg;

    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_PICK = 2'd1;
    localparam logic [1:0] CMD_MARK = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_REJECT  = 3'd1;
    localparam logic [2:0] ST_NOPICK  = 3'd2;
    localparam logic [2:0] ST_DEFAULT = 3'd3;
    localparam logic [2:0] ST_ENTRY   = 3'd4;

    localparam logic [2:0] MUL_X  = 3'd0;
    localparam logic [2:0] MUL_Z  = 3'd1;
    localparam logic [2:0] MUL_L  = 3'd2;
    localparam logic [2:0] MUL_F1 = 3'd3;
    localparam logic [2:0] MUL_F2 = 3'd4;

    localparam logic [63:0] C_X  = 64'd341873128712;
    localparam logic [63:0] C_Z  = 64'd132897987541;
    localparam logic [63:0] C_L  = 64'd668268263;
    localparam logic [63:0] C_F1 = 64'hFF51AFD7ED558CCD;
    localparam logic [63:0] C_F2 = 64'hC4CEB9FE1A85EC53;

    localparam int DEFAULT_WEIGHT = 256;
    localparam int MUL_STEPS      = 16;  // 4 multiplier bits per step
    localparam int DIV_STEPS      = 64;  // 1 quotient bit per step

    typedef struct packed {
        logic       latch;
        logic       simple;
        logic       sum_start;
        logic       sum_step;
        logic       mul_start;
        logic       mul_step;
        logic       mul_end;
        logic [2:0] mul_sel;
        logic       div_start;
        logic       div_step;
        logic       check;
        logic       walk_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic pick_go;
        logic sum_done;
        logic is_default;
        logic walk_done;
    } dp_stat_t;

    function automatic logic [63:0] mul_const(input logic [2:0] sel);
        logic [63:0] c;
        case (sel)
            MUL_X:   c = C_X;
            MUL_Z:   c = C_Z;
            MUL_L:   c = C_L;
            MUL_F1:  c = C_F1;
            MUL_F2:  c = C_F2;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

/* rtl/hashed_weighted_select.sv */
// Hashed weighted selection over NUM_LISTS lists of up to MAX_ENTRIES entries.
// Request channel: start with the command fields; a request is taken at a
// rising edge with start high and busy low. busy stays high until the result.
// Result channel: done is high for one cycle with status and chosen_id; the
// receiver cannot stall, so the result must be taken in that cycle.
// Sequence: add, mark, a bad command and a pick of an empty or absent list
//   go from decode straight to the response. Any other pick sums the weights,
//   runs five multiplies (load, 16 steps of 4 multiplier bits, finish) and a
//   64-step remainder unit, then walks the entries unless the default wins
//   (the walk stops at the first chosen entry or at the last entry).
// One request at a time: the next start is taken the cycle after done.
// Reset clears entry counts, the valid-id map and the controller; entry
// memory contents are not cleared (only entries below the count are read).
module hashed_weighted_select
    import hws_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    parameter int NUM_LISTS   = 3
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         command,
    input  logic [1:0]         list_select,
    input  logic [7:0]         entry_id,
    input  logic [15:0]        entry_weight,
    input  logic signed [63:0] world_seed,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_z,
    input  logic               default_present,
    input  logic [7:0]         default_id,
    output logic               done,
    output logic [2:0]         status,
    output logic [7:0]         chosen_id
);

    ctrl_cmd_t ctrl_cmd;
    dp_stat_t  dp_stat;

    // sequencer: one state per phase of a request
    hws_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (dp_stat),
        .cmd   (ctrl_cmd),
        .busy  (busy),
        .done  (done)
    );

    // storage, hash multiplier, remainder unit and walk logic
    hws_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .NUM_LISTS   (NUM_LISTS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (ctrl_cmd),
        .command         (command),
        .list_select     (list_select),
        .entry_id        (entry_id),
        .entry_weight    (entry_weight),
        .world_seed      (world_seed),
        .coord_x         (coord_x),
        .coord_z         (coord_z),
        .default_present (default_present),
        .default_id      (default_id),
        .stat            (dp_stat),
        .status          (status),
        .chosen_id       (chosen_id)
    );

endmodule

/* rtl/hws_ctrl.sv */
module hws_ctrl
    import hws_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd,
    output logic      busy,
    output logic      done
);
`include "hashed_weighted_select_defines.svh"

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_SUM    = 4'd2;
    localparam logic [3:0] S_MLOAD  = 4'd3;
    localparam logic [3:0] S_MRUN   = 4'd4;
    localparam logic [3:0] S_MEND   = 4'd5;
    localparam logic [3:0] S_DLOAD  = 4'd6;
    localparam logic [3:0] S_DRUN   = 4'd7;
    localparam logic [3:0] S_CHECK  = 4'd8;
    localparam logic [3:0] S_WALK   = 4'd9;
    localparam logic [3:0] S_RESP   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [2:0] sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            sel_reg   <= MUL_X;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.mul_sel = sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.pick_go)
                begin
                    cmd.sum_start = 1'b1;
                    sel_next      = MUL_X;
                    state_next    = S_SUM;
                end
                else
                begin
                    cmd.simple = 1'b1;
                    state_next = S_RESP;
                end
            end
            S_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (stat.sum_done)
                    state_next = S_MLOAD;
            end
            S_MLOAD:
            begin
                cmd.mul_start = 1'b1;
                cnt_next      = '0;
                state_next    = S_MRUN;
            end
            S_MRUN:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == 6'(MUL_STEPS - 1))
                    state_next = S_MEND;
            end
            S_MEND:
            begin
                cmd.mul_end = 1'b1;
                if (sel_reg == MUL_F2)
                    state_next = S_DLOAD;
                else
                begin
                    sel_next   = sel_reg + 3'd1;
                    state_next = S_MLOAD;
                end
            end
            S_DLOAD:
            begin
                cmd.div_start = 1'b1;
                cnt_next      = '0;
                state_next    = S_DRUN;
            end
            S_DRUN:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_STEPS - 1))
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = stat.is_default ? S_RESP : S_WALK;
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (stat.walk_done)
                    state_next = S_RESP;
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_RESP);

    `HWS_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    `HWS_ASSERT_NXT(a_done_single, done, !done && !busy)
    `HWS_ASSERT_IMP(a_walk_not_default, state_reg == S_WALK, !cmd.check && !cmd.simple)

endmodule

/* rtl/hws_dp.sv */
module hws_dp
    import hws_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    parameter int NUM_LISTS   = 3
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          cmd,
    input  logic [1:0]         command,
    input  logic [1:0]         list_select,
    input  logic [7:0]         entry_id,
    input  logic [15:0]        entry_weight,
    input  logic signed [63:0] world_seed,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_z,
    input  logic               default_present,
    input  logic [7:0]         default_id,
    output dp_stat_t           stat,
    output logic [2:0]         status,
    output logic [7:0]         chosen_id
);

    localparam int DEPTH  = NUM_LISTS * MAX_ENTRIES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int LSEL_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int TOT_W  = $clog2(DEFAULT_WEIGHT + MAX_ENTRIES * 65535 + 1);

    // latched request
    logic [1:0]  cmd_reg;
    logic [1:0]  list_reg;
    logic [7:0]  id_reg;
    logic [15:0] weight_reg;
    logic [31:0] x_reg;
    logic [31:0] z_reg;
    logic        dflt_reg;
    logic [7:0]  did_reg;

    // hash / multiply / divide
    logic [63:0]      h_reg;
    logic [63:0]      a_reg;
    logic [63:0]      b_reg;
    logic [63:0]      prod_reg;
    logic [TOT_W-1:0] total_reg;
    logic [TOT_W-1:0] rem_reg;

    // entry walk
    logic [CNT_W-1:0] cnt_reg [NUM_LISTS];
    logic [255:0]     valid_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             pend_reg;
    logic             pend_last_reg;
    logic [2:0]       res_status_reg;
    logic [7:0]       res_id_reg;

    logic [23:0] mem [DEPTH];
    logic [23:0] rd_data_reg;

    logic [LSEL_W-1:0] lidx;
    logic              list_ok;
    logic [CNT_W-1:0]  count_cur;
    logic              add_ok;
    logic              mem_we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic              issue;
    logic [TOT_W-1:0]  dw;
    logic [7:0]        rd_id;
    logic [TOT_W-1:0]  rd_w;
    logic              rd_valid;
    logic              roll_in;
    logic              hit;
    logic [63:0]       a_sel;
    logic [63:0]       hx;
    logic [TOT_W:0]    trial;

    assign lidx      = LSEL_W'(list_reg);
    assign list_ok   = (int'(list_reg) < NUM_LISTS);
    assign count_cur = list_ok ? cnt_reg[lidx] : '0;
    assign add_ok    = list_ok && (weight_reg != 16'd0) && (count_cur < CNT_W'(MAX_ENTRIES));
    assign mem_we    = cmd.simple && (cmd_reg == CMD_ADD) && add_ok;
    assign waddr     = ADDR_W'(int'(lidx) * MAX_ENTRIES + int'(count_cur));
    assign raddr     = ADDR_W'(int'(lidx) * MAX_ENTRIES + int'(idx_reg));
    assign issue     = (cmd.sum_step || cmd.walk_step) && (idx_reg < count_cur);
    assign dw        = dflt_reg ? TOT_W'(DEFAULT_WEIGHT) : '0;

    assign rd_id    = rd_data_reg[23:16];
    assign rd_w     = TOT_W'(rd_data_reg[15:0]);
    assign rd_valid = valid_reg[rd_id];
    assign roll_in  = (rem_reg < rd_w);
    assign hit      = roll_in && rd_valid;

    assign stat.pick_go    = (cmd_reg == CMD_PICK) && list_ok && (count_cur != '0);
    assign stat.sum_done   = pend_reg && pend_last_reg;
    assign stat.is_default = (rem_reg < dw);
    assign stat.walk_done  = pend_reg && (hit || pend_last_reg);

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_X:   a_sel = {{32{x_reg[31]}}, x_reg};
            MUL_Z:   a_sel = {{32{z_reg[31]}}, z_reg};
            MUL_L:   a_sel = {62'd0, list_reg};
            default: a_sel = h_reg;
        endcase
    end

    assign hx    = h_reg ^ prod_reg;
    assign trial = {rem_reg, h_reg[63]};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= {id_reg, weight_reg};
        rd_data_reg <= mem[raddr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LISTS; i++)
                cnt_reg[i] <= '0;
            valid_reg     <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
                cnt_reg[lidx] <= count_cur + CNT_W'(1);
            if (cmd.simple && (cmd_reg == CMD_MARK))
                valid_reg[id_reg] <= 1'b1;
            if (cmd.sum_start || cmd.check)
            begin
                idx_reg  <= '0;
                pend_reg <= 1'b0;
            end
            else if (cmd.sum_step || cmd.walk_step)
            begin
                pend_reg <= issue;
                if (issue)
                begin
                    idx_reg       <= idx_reg + CNT_W'(1);
                    pend_last_reg <= (idx_reg == count_cur - CNT_W'(1));
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cmd_reg    <= command;
            list_reg   <= list_select;
            id_reg     <= entry_id;
            weight_reg <= entry_weight;
            x_reg      <= coord_x;
            z_reg      <= coord_z;
            dflt_reg   <= default_present;
            did_reg    <= default_id;
            h_reg      <= world_seed;
        end

        if (cmd.simple)
        begin
            res_id_reg <= 8'd0;
            case (cmd_reg)
                CMD_ADD:  res_status_reg <= add_ok ? ST_OK : ST_REJECT;
                CMD_PICK: res_status_reg <= ST_NOPICK;
                CMD_MARK: res_status_reg <= ST_OK;
                default:  res_status_reg <= ST_REJECT;
            endcase
        end

        if (cmd.sum_start)
            total_reg <= dw;
        else if (cmd.sum_step && pend_reg)
            total_reg <= total_reg + rd_w;

        // 64x64 low product, 4 multiplier bits per step
        if (cmd.mul_start)
        begin
            a_reg    <= a_sel;
            b_reg    <= mul_const(cmd.mul_sel);
            prod_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            prod_reg <= prod_reg + a_reg * b_reg[3:0];
            a_reg    <= a_reg << 4;
            b_reg    <= b_reg >> 4;
        end

        if (cmd.mul_end)
        begin
            case (cmd.mul_sel)
                MUL_L:   h_reg <= hx ^ (hx >> 33);
                MUL_F1,
                MUL_F2:  h_reg <= prod_reg ^ (prod_reg >> 33);
                default: h_reg <= hx;
            endcase
        end
        else if (cmd.div_step)
            h_reg <= h_reg << 1;

        // restoring remainder, hash bits shifted in from the top
        if (cmd.div_start)
            rem_reg <= '0;
        else if (cmd.div_step)
        begin
            if (trial >= {1'b0, total_reg})
                rem_reg <= TOT_W'(trial - {1'b0, total_reg});
            else
                rem_reg <= TOT_W'(trial);
        end
        else if (cmd.check)
        begin
            if (stat.is_default)
            begin
                res_status_reg <= ST_DEFAULT;
                res_id_reg     <= did_reg;
            end
            else
                rem_reg <= rem_reg - dw;
        end
        else if (cmd.walk_step && pend_reg)
        begin
            rem_reg <= roll_in ? '0 : rem_reg - rd_w;
            // last entry: chosen exactly when its id is valid
            if (hit || pend_last_reg)
            begin
                res_status_reg <= rd_valid ? ST_ENTRY : ST_NOPICK;
                res_id_reg     <= rd_valid ? rd_id : 8'd0;
            end
        end
    end

    assign status    = res_status_reg;
    assign chosen_id = res_id_reg;

endmodule
